/* rtl/core/ltfmf_pkg.sv */
// Package for the lateral tire force unit: widths, fixed-point constants,
// CORDIC angle table, payload structs and arithmetic helpers. No dependencies.
package ltfmf_pkg;

	localparam int ATAN_STEPS = 24;
	localparam int N_STEPS    = (ATAN_STEPS > 32) ? 32 : ATAN_STEPS;

	localparam int VW = 50;   // vectoring CORDIC x/y
	localparam int AW = 34;   // Q2.30 angles
	localparam int SW = 34;   // rotation CORDIC x/y

	typedef logic signed [VW-1:0] vec_t;
	typedef logic signed [AW-1:0] ang_t;
	typedef logic signed [SW-1:0] sin_t;
	typedef logic signed [71:0]   wide_t;
	typedef logic signed [31:0]   q16_t;

	typedef struct packed {
		vec_t x;
		vec_t y;
		ang_t z;
	} vec_state_t;

	typedef struct packed {
		sin_t x;
		sin_t y;
		ang_t r;
	} sin_state_t;

	typedef struct packed {
		logic below;
		logic vz_zero;
		logic vx_pos;
		logic vx_neg;
	} slip_side_t;

	typedef struct packed {
		logic below;
		q16_t t1;
	} arg_side_t;

	typedef struct packed {
		logic signed [31:0] lateral_velocity;
		logic signed [31:0] forward_velocity;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] lateral_force;
		logic               below_speed;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [31:0] value;
	} cfg_item_t;

	typedef enum logic [2:0] {
		REG_B   = 3'd0,
		REG_C   = 3'd1,
		REG_D   = 3'd2,
		REG_E   = 3'd3,
		REG_SH  = 3'd4,
		REG_SV  = 3'd5,
		REG_MIN = 3'd6
	} cfg_idx_t;

	localparam ang_t Q30_PI      = 34'sd3373259426;
	localparam ang_t Q30_HALF_PI = 34'sd1686629713;
	localparam ang_t Q30_TWO_PI  = 34'sd6746518852;
	localparam sin_t INV_GAIN    = 34'sd652032874;
	localparam logic signed [23:0] DEG_PER_RAD = 24'sd3754937;
	localparam logic signed [33:0] NINETY_DEG  = 34'sd5898240;
	localparam vec_t VEC_ONE     = 50'sd4294967296;   // 1.0 Q16.16 scaled by 2^16
	localparam logic [32:0] TWO_PI_U = 33'd6746518852;
	// floor(2^52 / 2pi in Q2.30): reciprocal for the modulo reduction
	localparam logic [19:0] RECIP_TWO_PI = 20'((64'd1 << 52) / 64'd6746518852);

	localparam logic [31:0] ANGLE_TAB [32] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001, 32'h00000000
	};

	function automatic q16_t sat32(wide_t v);
		if (v > wide_t'(33'sh0_7FFF_FFFF))
			return 32'sh7FFF_FFFF;
		if (v < -wide_t'(33'sh0_8000_0000))
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// product of two Q16.16 values, rounded half up and saturated
	function automatic q16_t qround16(wide_t p);
		wide_t r;
		r = (p + wide_t'(33'sd32768)) >>> 16;
		return sat32(r);
	endfunction

	function automatic ang_t tab_angle(int unsigned i);
		return ang_t'({2'b00, ANGLE_TAB[i[4:0]]});
	endfunction

	function automatic vec_state_t vec_step(vec_state_t s, int unsigned i);
		vec_t xs;
		vec_t ys;
		vec_state_t o;
		xs = $signed(s.x) >>> i;
		ys = $signed(s.y) >>> i;
		if ($signed(s.y) > 0) begin
			o.x = s.x + ys;
			o.y = s.y - xs;
			o.z = s.z + tab_angle(i);
		end else begin
			o.x = s.x - ys;
			o.y = s.y + xs;
			o.z = s.z - tab_angle(i);
		end
		return o;
	endfunction

	function automatic sin_state_t sin_step(sin_state_t s, int unsigned i);
		sin_t xs;
		sin_t ys;
		sin_state_t o;
		xs = $signed(s.x) >>> i;
		ys = $signed(s.y) >>> i;
		if ($signed(s.r) >= 0) begin
			o.x = s.x - ys;
			o.y = s.y + xs;
			o.r = s.r - tab_angle(i);
		end else begin
			o.x = s.x + ys;
			o.y = s.y - xs;
			o.r = s.r + tab_angle(i);
		end
		return o;
	endfunction

endpackage

/* rtl/core/ltfmf_if.sv */
// Valid/ready channel interfaces of the lateral tire force unit.
// Depends on ltfmf_pkg for the payload structs.
interface ltfmf_in_if;
	import ltfmf_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ltfmf_out_if;
	import ltfmf_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ltfmf_cfg_if;
	import ltfmf_pkg::*;
	logic      valid;
	logic      ready;
	cfg_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/lateral_tire_force_magic_formula_unit.sv */
// Lateral tire force unit (Pacejka magic formula), Q16.16 fixed point.
// Depends on ltfmf_pkg and the channel interfaces in ltfmf_if.sv.
//
// Usage
//   in_ch  : one transaction per wheel, lateral and forward velocity.
//   out_ch : one transaction per input, lateral force and below_speed flag.
//   cfg_ch : register writes (index 0..6 = B, C, D, E, Sh, Sv, min speed^2);
//            always ready, an index past the list is ignored. Write only
//            while no transaction is in flight.
// Throughput: one transaction per cycle while out_ch takes results; the whole pipeline moves together.
// Pipeline: the four CORDIC units hold most of the stages, one micro-rotation
//   per stage: slip atan, inner atan, outer atan and sine.
// Stall: when the output register holds a result that out_ch does not take,
//   every stage holds, in_ch.ready drops, nothing is dropped or repeated.
// Reset: arst_n clears all valid bits and loads the register defaults
//   (C = 1.0, min speed^2 = 3277, the rest zero). No clearing pass.
module lateral_tire_force_magic_formula_unit (
	input logic clk,
	input logic arst_n,
	ltfmf_in_if.sink    in_ch,
	ltfmf_out_if.source out_ch,
	ltfmf_cfg_if.sink   cfg_ch
);
	import ltfmf_pkg::*;

	// ---------------- configuration registers ----------------
	q16_t        b_q, c_q, d_q, e_q, sh_q, sv_q;
	logic [30:0] min_q;
	q16_t        be_q;   // qmul(B, sat(1 - E)), follows the registers

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q   <= '0;
			c_q   <= 32'sd65536;
			d_q   <= '0;
			e_q   <= '0;
			sh_q  <= '0;
			sv_q  <= '0;
			min_q <= 31'd3277;
		end else if (cfg_ch.valid) begin
			case (cfg_idx_t'(cfg_ch.data.index))
				REG_B:   b_q   <= cfg_ch.data.value;
				REG_C:   c_q   <= cfg_ch.data.value;
				REG_D:   d_q   <= cfg_ch.data.value;
				REG_E:   e_q   <= cfg_ch.data.value;
				REG_SH:  sh_q  <= cfg_ch.data.value;
				REG_SV:  sv_q  <= cfg_ch.data.value;
				REG_MIN: min_q <= cfg_ch.data.value[30:0];
				default: ;
			endcase
		end
	end

	q16_t               one_minus_e;
	logic signed [63:0] be_prod;
	assign one_minus_e = sat32(wide_t'(33'sd65536) - wide_t'(e_q));
	assign be_prod     = b_q * one_minus_e;

	always_ff @(posedge clk) begin
		be_q <= qround16(wide_t'(be_prod));
	end

	// ---------------- pipeline advance ----------------
	// Output register is the only place a stall starts; all stages share it.
	logic      ovalid_q;
	out_item_t odata_q;
	logic      adv;

	assign adv         = !ovalid_q || out_ch.ready;
	assign in_ch.ready = adv;

	// stage valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic v_s10, v_s11, v_s12, v_s13, v_s14, v_s15, v_s16, v_s17;

	// CORDIC unit registers: index k holds the state after k micro-rotations
	vec_state_t c1_s [1:N_STEPS];
	slip_side_t c1_sd [1:N_STEPS];
	logic       c1_v [1:N_STEPS];
	vec_state_t c2_s [1:N_STEPS];
	arg_side_t  c2_sd [1:N_STEPS];
	logic       c2_v [1:N_STEPS];
	vec_state_t c3_s [1:N_STEPS];
	logic       c3_b [1:N_STEPS];
	logic       c3_v [1:N_STEPS];
	sin_state_t c4_s [1:N_STEPS];
	logic       c4_b [1:N_STEPS];
	logic       c4_v [1:N_STEPS];

	// ---------------- s1: magnitudes squared ----------------
	logic signed [31:0] vx, vz;
	logic [31:0]        ax, az;
	assign vx = in_ch.data.lateral_velocity;
	assign vz = in_ch.data.forward_velocity;
	assign ax = vx[31] ? 32'(-vx) : 32'(vx);
	assign az = vz[31] ? 32'(-vz) : 32'(vz);

	logic [63:0]        sqx_s1, sqz_s1;
	logic signed [32:0] cy_s1;
	logic [31:0]        cx_s1;
	slip_side_t         sd_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s1 <= ax * ax;
			sqz_s1 <= az * az;
			// fold the left half plane: atan(vx/vz) keeps its sign on -vx/|vz|
			cy_s1  <= vz[31] ? -33'(vx) : 33'(vx);
			cx_s1  <= az;
			sd_s1.below   <= 1'b0;
			sd_s1.vz_zero <= (vz == 32'sd0);
			sd_s1.vx_pos  <= (vx > 32'sd0);
			sd_s1.vx_neg  <= vx[31];
		end
	end

	// ---------------- s2: speed test ----------------
	logic signed [32:0] cy_s2;
	logic [31:0]        cx_s2;
	slip_side_t         sd_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			cy_s2 <= cy_s1;
			cx_s2 <= cx_s1;
			sd_s2.vz_zero <= sd_s1.vz_zero;
			sd_s2.vx_pos  <= sd_s1.vx_pos;
			sd_s2.vx_neg  <= sd_s1.vx_neg;
			sd_s2.below   <= sd_s1.below |
				((sqx_s1 + sqz_s1) < {17'd0, min_q, 16'd0});
		end
	end

	vec_state_t c1_in;
	assign c1_in.x = vec_t'($signed({2'b00, cx_s2, 16'h0000}));
	assign c1_in.y = vec_t'($signed({cy_s2, 16'h0000}));
	assign c1_in.z = '0;

	// ---------------- CORDIC 1: slip angle atan ----------------
	for (genvar i = 0; i < N_STEPS; i++) begin : g_c1
		vec_state_t prev;
		slip_side_t prev_sd;
		logic       prev_v;
		if (i == 0) begin : g_first
			assign prev    = c1_in;
			assign prev_sd = sd_s2;
			assign prev_v  = v_s2;
		end else begin : g_next
			assign prev    = c1_s[i];
			assign prev_sd = c1_sd[i];
			assign prev_v  = c1_v[i];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				c1_v[i+1] <= 1'b0;
			else if (adv)
				c1_v[i+1] <= prev_v;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				c1_s[i+1]  <= vec_step(prev, i);
				c1_sd[i+1] <= prev_sd;
			end
		end
	end

	// ---------------- s3: radians to degrees ----------------
	logic signed [57:0] degp_s3;
	slip_side_t         sd_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			degp_s3 <= c1_s[N_STEPS].z * DEG_PER_RAD;
			sd_s3   <= c1_sd[N_STEPS];
		end
	end

	// ---------------- s4: slip, plus horizontal shift ----------------
	logic signed [57:0] degr;
	logic signed [33:0] slip;
	q16_t               xs_s4;
	logic               b_s4;

	always_comb begin
		degr = (degp_s3 + 58'sd536870912) >>> 30;
		if (sd_s3.vz_zero) begin
			// sideways motion only: slip is minus 90 degrees times sign(vx)
			if (sd_s3.vx_pos)
				slip = -NINETY_DEG;
			else if (sd_s3.vx_neg)
				slip = NINETY_DEG;
			else
				slip = '0;
		end else begin
			slip = -34'(degr);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xs_s4 <= sat32(wide_t'(slip) + wide_t'(sh_q));
			b_s4  <= sd_s3.below;
		end
	end

	// ---------------- s5/s6: B*x and B(1-E)*x ----------------
	logic signed [63:0] pb_s5, pt_s5;
	logic               b_s5;
	q16_t               bx_s6;
	arg_side_t          sd_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			pb_s5 <= b_q * xs_s4;
			pt_s5 <= be_q * xs_s4;
			b_s5  <= b_s4;
			bx_s6 <= qround16(wide_t'(pb_s5));
			sd_s6.t1    <= qround16(wide_t'(pt_s5));
			sd_s6.below <= b_s5;
		end
	end

	vec_state_t c2_in;
	assign c2_in.x = VEC_ONE;
	assign c2_in.y = vec_t'($signed({bx_s6, 16'h0000}));
	assign c2_in.z = '0;

	// ---------------- CORDIC 2: inner atan(Bx) ----------------
	for (genvar i = 0; i < N_STEPS; i++) begin : g_c2
		vec_state_t prev;
		arg_side_t  prev_sd;
		logic       prev_v;
		if (i == 0) begin : g_first
			assign prev    = c2_in;
			assign prev_sd = sd_s6;
			assign prev_v  = v_s6;
		end else begin : g_next
			assign prev    = c2_s[i];
			assign prev_sd = c2_sd[i];
			assign prev_v  = c2_v[i];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				c2_v[i+1] <= 1'b0;
			else if (adv)
				c2_v[i+1] <= prev_v;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				c2_s[i+1]  <= vec_step(prev, i);
				c2_sd[i+1] <= prev_sd;
			end
		end
	end

	// ---------------- s7/s8: E*atan and the outer argument ----------------
	ang_t               at1;
	logic signed [65:0] pe_s7;
	arg_side_t          sd_s7;
	q16_t               arg_s8;
	logic               b_s8;

	assign at1 = (c2_s[N_STEPS].z + ang_t'(34'sd8192)) >>> 14;   // Q2.30 to Q16.16

	always_ff @(posedge clk) begin
		if (adv) begin
			pe_s7  <= e_q * at1;
			sd_s7  <= c2_sd[N_STEPS];
			arg_s8 <= sat32(wide_t'(sd_s7.t1) + wide_t'(qround16(wide_t'(pe_s7))));
			b_s8   <= sd_s7.below;
		end
	end

	vec_state_t c3_in;
	assign c3_in.x = VEC_ONE;
	assign c3_in.y = vec_t'($signed({arg_s8, 16'h0000}));
	assign c3_in.z = '0;

	// ---------------- CORDIC 3: outer atan ----------------
	for (genvar i = 0; i < N_STEPS; i++) begin : g_c3
		vec_state_t prev;
		logic       prev_b;
		logic       prev_v;
		if (i == 0) begin : g_first
			assign prev   = c3_in;
			assign prev_b = b_s8;
			assign prev_v = v_s8;
		end else begin : g_next
			assign prev   = c3_s[i];
			assign prev_b = c3_b[i];
			assign prev_v = c3_v[i];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				c3_v[i+1] <= 1'b0;
			else if (adv)
				c3_v[i+1] <= prev_v;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				c3_s[i+1] <= vec_step(prev, i);
				c3_b[i+1] <= prev_b;
			end
		end
	end

	// ---------------- s9..s14: phi = C*atan, reduced modulo 2pi ----------------
	// |phi| < 2^46; quotient from a reciprocal multiply, low by at most one,
	// fixed with one compare and subtract. Remainder keeps the sign of phi.
	logic signed [65:0] cp_s9;
	logic               b_s9;
	logic signed [49:0] phi;
	logic [47:0]        abs_s10, abs_s11, abs_s12;
	logic               neg_s10, neg_s11, neg_s12, neg_s13;
	logic               b_s10, b_s11, b_s12, b_s13, b_s14;
	logic [47:0]        qp;
	logic [14:0]        q_s11;
	logic [47:0]        qt_s12;
	logic [33:0]        m_s13;
	logic [33:0]        m2;
	ang_t               r_s14;

	assign phi = 50'(cp_s9 >>> 16);
	assign qp  = abs_s10[47:20] * RECIP_TWO_PI;
	assign m2  = (m_s13 >= 34'(TWO_PI_U)) ? m_s13 - 34'(TWO_PI_U) : m_s13;

	always_ff @(posedge clk) begin
		if (adv) begin
			cp_s9   <= c_q * c3_s[N_STEPS].z;
			b_s9    <= c3_b[N_STEPS];
			neg_s10 <= phi[49];
			abs_s10 <= phi[49] ? 48'(-phi) : 48'(phi);
			b_s10   <= b_s9;
			q_s11   <= qp[46:32];
			abs_s11 <= abs_s10;
			neg_s11 <= neg_s10;
			b_s11   <= b_s10;
			qt_s12  <= q_s11 * TWO_PI_U;
			abs_s12 <= abs_s11;
			neg_s12 <= neg_s11;
			b_s12   <= b_s11;
			m_s13   <= 34'(abs_s12 - qt_s12);
			neg_s13 <= neg_s12;
			b_s13   <= b_s12;
			r_s14   <= neg_s13 ? -$signed(m2) : $signed(m2);
			b_s14   <= b_s13;
		end
	end

	// ---------------- s15/s16: fold into [-pi/2, pi/2] ----------------
	ang_t r_s15, r_s16;
	logic b_s15, b_s16;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (r_s14 >= Q30_PI)
				r_s15 <= r_s14 - Q30_TWO_PI;
			else if (r_s14 < -Q30_PI)
				r_s15 <= r_s14 + Q30_TWO_PI;
			else
				r_s15 <= r_s14;
			b_s15 <= b_s14;
			if (r_s15 > Q30_HALF_PI)
				r_s16 <= Q30_PI - r_s15;
			else if (r_s15 < -Q30_HALF_PI)
				r_s16 <= -Q30_PI - r_s15;
			else
				r_s16 <= r_s15;
			b_s16 <= b_s15;
		end
	end

	sin_state_t c4_in;
	assign c4_in.x = INV_GAIN;
	assign c4_in.y = '0;
	assign c4_in.r = r_s16;

	// ---------------- CORDIC 4: sine ----------------
	for (genvar i = 0; i < N_STEPS; i++) begin : g_c4
		sin_state_t prev;
		logic       prev_b;
		logic       prev_v;
		if (i == 0) begin : g_first
			assign prev   = c4_in;
			assign prev_b = b_s16;
			assign prev_v = v_s16;
		end else begin : g_next
			assign prev   = c4_s[i];
			assign prev_b = c4_b[i];
			assign prev_v = c4_v[i];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				c4_v[i+1] <= 1'b0;
			else if (adv)
				c4_v[i+1] <= prev_v;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				c4_s[i+1] <= sin_step(prev, i);
				c4_b[i+1] <= prev_b;
			end
		end
	end

	// ---------------- s17 and output: D*sin + Sv ----------------
	logic signed [65:0] dp_s17;
	logic               b_s17;
	wide_t              dsin;
	q16_t               force_val;

	assign dsin      = (wide_t'(dp_s17) + wide_t'(34'sd536870912)) >>> 30;
	assign force_val = sat32(dsin + wide_t'(sv_q));

	always_ff @(posedge clk) begin
		if (adv) begin
			dp_s17 <= d_q * c4_s[N_STEPS].y;
			b_s17  <= c4_b[N_STEPS];
			odata_q.lateral_force <= b_s17 ? 32'sd0 : force_val;
			odata_q.below_speed   <= b_s17;
		end
	end

	// fixed-stage valid bits and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
			{v_s10, v_s11, v_s12, v_s13, v_s14, v_s15, v_s16, v_s17} <= '0;
			ovalid_q <= 1'b0;
		end else if (adv) begin
			v_s1     <= in_ch.valid;
			v_s2     <= v_s1;
			v_s3     <= c1_v[N_STEPS];
			v_s4     <= v_s3;
			v_s5     <= v_s4;
			v_s6     <= v_s5;
			v_s7     <= c2_v[N_STEPS];
			v_s8     <= v_s7;
			v_s9     <= c3_v[N_STEPS];
			v_s10    <= v_s9;
			v_s11    <= v_s10;
			v_s12    <= v_s11;
			v_s13    <= v_s12;
			v_s14    <= v_s13;
			v_s15    <= v_s14;
			v_s16    <= v_s15;
			v_s17    <= c4_v[N_STEPS];
			ovalid_q <= v_s17;
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.data  = odata_q;

	// ---------------- assertions ----------------
	// the reduced angle fed to the sine unit lies in [-pi/2, pi/2]
	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s16 |-> (r_s16 <= Q30_HALF_PI && r_s16 >= -Q30_HALF_PI))
		else $error("sine input angle out of range");

	// a stalled pipeline keeps the valid bits of s9, the last outer atan step and s17
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(v_s9) && $stable(c3_v[N_STEPS]) && $stable(v_s17)))
		else $error("pipeline moved during stall");

	// below-speed results carry a zero force
	a_below_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.data.below_speed) |-> out_ch.data.lateral_force == 32'sd0)
		else $error("below-speed result with nonzero force");

	// the remainder after correction is below 2pi
	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s13 |-> m2 < 34'(TWO_PI_U))
		else $error("modulo reduction out of range");

endmodule
